### hw/rtl/rpw_pkg.sv
`default_nettype none

package rpw_pkg;

	localparam int WINDOW_BYTES = 16;
	localparam int BUFFER_BYTES = 8192;
	localparam int PAT_MAX      = (WINDOW_BYTES < 16) ? WINDOW_BYTES : 16;
	localparam int LEN_W        = $clog2(PAT_MAX + 1);
	localparam int POS_W        = $clog2(PAT_MAX);
	localparam int CNT_W        = 14;
	localparam int KB_SHIFT     = 10;
	localparam int KB_W         = CNT_W - KB_SHIFT;
	localparam int TMO_W        = 16;
	localparam int THR_W        = TMO_W + KB_W + 1;
	localparam int TIMER_W      = 32;
	localparam int RETRY_W      = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	localparam logic [63:0] PATTERN_LOW_RST  = 64'd19279;
	localparam logic [63:0] PATTERN_HIGH_RST = 64'd0;
	localparam logic [4:0]  PATTERN_LEN_RST  = 5'd2;
	localparam logic [7:0]  MAX_RETRIES_RST  = 8'd5;
	localparam logic [15:0] BASE_TMO_RST     = 16'd8000;
	localparam logic [15:0] PER_KB_TMO_RST   = 16'd150;

	typedef enum logic [1:0] {
		MODE_BYTE  = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_START = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_WAIT   = 3'd0,
		ST_MATCH  = 3'd1,
		ST_RESEND = 3'd2,
		ST_FAIL   = 3'd3,
		ST_IDLE   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW    = 3'd0,
		REG_PAT_HIGH   = 3'd1,
		REG_PAT_LEN    = 3'd2,
		REG_MAX_RETRY  = 3'd3,
		REG_BASE_TMO   = 3'd4,
		REG_PER_KB_TMO = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/rpw_cell.sv
`default_nettype none

module rpw_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rpw_pkg::cell_ctl_t ctl,
	input  wire logic [7:0]        left,
	input  wire logic [7:0]        pat,
	input  wire logic              in_use,
	output logic      [7:0]        data,
	output logic                   hit
);

	logic [7:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= 8'd0;
		end else if (ctl.clear) begin
			data_q <= 8'd0;
		end else if (ctl.shift) begin
			data_q <= left;
		end
	end

	assign data = data_q;
	// compare the byte this cell takes on the shift
	assign hit  = !in_use || (left == pat);

endmodule

`default_nettype wire

### hw/rtl/response_pattern_waiter.sv
// A result appears in the cycle after its input is accepted. Throughput:
// one transaction per cycle unless stalled; the window compare across the
// cell chain and the timeout threshold are evaluated in the accepting cycle.
// Reset (asynchronous, active low): idle, window, count, timer and retries
// cleared, registers back to their defaults, no result pending.
`default_nettype none

module response_pattern_waiter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [rpw_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [rpw_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            mode,
	input  wire logic [7:0]                            rx_byte,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [2:0]                                 status,
	output logic [7:0]                                 attempt,
	output logic [13:0]                                stored_count
);

	logic [63:0]                         pattern_low_q;
	logic [63:0]                         pattern_high_q;
	logic [4:0]                          pattern_length_q;
	logic [rpw_pkg::RETRY_W-1:0]         max_retries_q;
	logic [rpw_pkg::TMO_W-1:0]           base_timeout_q;
	logic [rpw_pkg::TMO_W-1:0]           per_kb_timeout_q;

	logic                                busy_q;
	logic [rpw_pkg::CNT_W-1:0]           count_q;
	logic [rpw_pkg::TIMER_W-1:0]         timer_q;
	logic [rpw_pkg::RETRY_W-1:0]         retry_q;

	logic                                out_valid_q;
	rpw_pkg::status_t                    status_q;
	logic [rpw_pkg::RETRY_W-1:0]         attempt_q;
	logic [rpw_pkg::CNT_W-1:0]           stored_q;

	logic                                acc;
	rpw_pkg::mode_t                      mode_in;
	logic [rpw_pkg::LEN_W-1:0]           len_eff;
	logic [rpw_pkg::CNT_W-1:0]           limit;
	logic [rpw_pkg::CNT_W-1:0]           count_inc;
	logic [127:0]                        pat_all;
	logic [rpw_pkg::THR_W-1:0]           threshold;
	logic [rpw_pkg::TIMER_W-1:0]         timer_inc;

	logic                                busy_n;
	logic [rpw_pkg::CNT_W-1:0]           count_n;
	logic [rpw_pkg::TIMER_W-1:0]         timer_n;
	logic [rpw_pkg::RETRY_W-1:0]         retry_n;
	rpw_pkg::status_t                    status_n;
	rpw_pkg::cell_ctl_t                  ctl;

	logic [7:0]                          win [rpw_pkg::WINDOW_BYTES];
	logic [rpw_pkg::WINDOW_BYTES-1:0]    hit;
	logic                                match;

	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;
	assign mode_in  = rpw_pkg::mode_t'(mode);
	assign pat_all  = {pattern_high_q, pattern_low_q};

	always_comb begin
		if (pattern_length_q == 5'd0) begin
			len_eff = rpw_pkg::LEN_W'(1);
		end else if (pattern_length_q > 5'(rpw_pkg::PAT_MAX)) begin
			len_eff = rpw_pkg::LEN_W'(rpw_pkg::PAT_MAX);
		end else begin
			len_eff = rpw_pkg::LEN_W'(pattern_length_q);
		end
	end

	assign limit     = rpw_pkg::CNT_W'(rpw_pkg::BUFFER_BYTES - 1) - rpw_pkg::CNT_W'(len_eff);
	assign count_inc = count_q + rpw_pkg::CNT_W'(1);
	assign threshold = rpw_pkg::THR_W'(base_timeout_q)
		+ rpw_pkg::THR_W'(per_kb_timeout_q)
		* rpw_pkg::THR_W'(count_q[rpw_pkg::CNT_W-1:rpw_pkg::KB_SHIFT]);
	assign timer_inc = (&timer_q) ? timer_q : timer_q + rpw_pkg::TIMER_W'(1);

	for (genvar j = 0; j < rpw_pkg::WINDOW_BYTES; j++) begin : g_cell
		logic [rpw_pkg::POS_W-1:0] pidx;
		logic [7:0]                pat;
		logic                      in_use;

		assign pidx   = rpw_pkg::POS_W'(len_eff - rpw_pkg::LEN_W'(1) - rpw_pkg::LEN_W'(j));
		assign pat    = pat_all[{pidx, 3'b000} +: 8];
		assign in_use = (j < rpw_pkg::PAT_MAX) && (rpw_pkg::LEN_W'(j) < len_eff);

		rpw_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   ((j == 0) ? rx_byte : win[(j == 0) ? 0 : j - 1]),
			.pat    (pat),
			.in_use (in_use),
			.data   (win[j]),
			.hit    (hit[j])
		);
	end

	assign match = (&hit) && (count_inc >= rpw_pkg::CNT_W'(len_eff));

	always_comb begin
		busy_n    = busy_q;
		count_n   = count_q;
		timer_n   = timer_q;
		retry_n   = retry_q;
		status_n  = busy_q ? rpw_pkg::ST_WAIT : rpw_pkg::ST_IDLE;
		ctl.shift = 1'b0;
		ctl.clear = 1'b0;
		if (acc) begin
			unique case (mode_in)
				rpw_pkg::MODE_START: begin
					busy_n    = 1'b1;
					count_n   = '0;
					timer_n   = '0;
					retry_n   = '0;
					ctl.clear = 1'b1;
					status_n  = rpw_pkg::ST_WAIT;
				end
				rpw_pkg::MODE_BYTE: begin
					if (busy_q) begin
						timer_n = '0;
						if (count_q < limit) begin
							ctl.shift = 1'b1;
							count_n   = count_inc;
							if (match) begin
								status_n = rpw_pkg::ST_MATCH;
								busy_n   = 1'b0;
							end
						end
					end
				end
				rpw_pkg::MODE_TICK: begin
					if (busy_q) begin
						timer_n = timer_inc;
						if (timer_inc > rpw_pkg::TIMER_W'(threshold)) begin
							if (retry_q < max_retries_q) begin
								retry_n   = retry_q + rpw_pkg::RETRY_W'(1);
								count_n   = '0;
								timer_n   = '0;
								ctl.clear = 1'b1;
								status_n  = rpw_pkg::ST_RESEND;
							end else begin
								status_n = rpw_pkg::ST_FAIL;
								busy_n   = 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= rpw_pkg::PATTERN_LOW_RST;
			pattern_high_q   <= rpw_pkg::PATTERN_HIGH_RST;
			pattern_length_q <= rpw_pkg::PATTERN_LEN_RST;
			max_retries_q    <= rpw_pkg::MAX_RETRIES_RST;
			base_timeout_q   <= rpw_pkg::BASE_TMO_RST;
			per_kb_timeout_q <= rpw_pkg::PER_KB_TMO_RST;
		end else if (cfg_we) begin
			unique case (rpw_pkg::cfg_reg_t'(cfg_index))
				rpw_pkg::REG_PAT_LOW:    pattern_low_q    <= cfg_data;
				rpw_pkg::REG_PAT_HIGH:   pattern_high_q   <= cfg_data;
				rpw_pkg::REG_PAT_LEN:    pattern_length_q <= cfg_data[4:0];
				rpw_pkg::REG_MAX_RETRY:  max_retries_q    <= cfg_data[7:0];
				rpw_pkg::REG_BASE_TMO:   base_timeout_q   <= cfg_data[15:0];
				rpw_pkg::REG_PER_KB_TMO: per_kb_timeout_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
			timer_q <= '0;
			retry_q <= '0;
		end else begin
			busy_q  <= busy_n;
			count_q <= count_n;
			timer_q <= timer_n;
			retry_q <= retry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q  <= status_n;
			attempt_q <= retry_n;
			stored_q  <= count_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign attempt      = attempt_q;
	assign stored_count = stored_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < rpw_pkg::CNT_W'(rpw_pkg::BUFFER_BYTES - 1))
		else $error("byte count beyond buffer limit");

	a_match_idles: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (status_n == rpw_pkg::ST_MATCH) |=> !busy_q)
		else $error("still busy after match");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (mode_in == rpw_pkg::MODE_START) |=>
		busy_q && (count_q == '0) && (retry_q == '0) && (timer_q == '0))
		else $error("start did not clear attempt state");
`endif

endmodule

`default_nettype wire
